@@ design/dtbs_pkg.sv @@
// ----------------------------------------------------------------------------
// dtbs_pkg
// shared types and constants of the dual transmit buffer scheduler
// ----------------------------------------------------------------------------
package dtbs_pkg;

  localparam int unsigned TX_PAGE_COUNT   = 12;
  localparam int unsigned MIN_FRAME_BYTES = 60;

  localparam int unsigned LEN_W  = 12;
  localparam int unsigned PLEN_W = 11;
  localparam int unsigned PAGE_W = 8;
  localparam int unsigned QCNT_W = 8;

  localparam logic [PAGE_W-1:0] SLOT_TWO_OFFSET = PAGE_W'(TX_PAGE_COUNT / 2);
  localparam logic [LEN_W-1:0]  MIN_LEN         = LEN_W'(MIN_FRAME_BYTES);
  localparam logic [PAGE_W-1:0] BASE_PAGE_RST   = 8'd64;

  typedef enum logic [1:0] {
    OP_SUBMIT = 2'd0,
    OP_DONE   = 2'd1,
    OP_ERROR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    MODE_FREE    = 2'd0,
    MODE_LOADED  = 2'd1,
    MODE_SENDING = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    CODE_NONE           = 3'd0,
    CODE_RESTART_ONE    = 3'd1,
    CODE_RESTART_TWO    = 3'd2,
    CODE_SUBMIT_ONE     = 3'd3,
    CODE_SUBMIT_TWO     = 3'd4,
    CODE_IDLE_AFTER_TWO = 3'd5,
    CODE_IDLE_AFTER_ONE = 3'd6
  } code_t;

  typedef enum logic [2:0] {
    ST_STARTED  = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_REJECTED = 3'd2,
    ST_HANDLED  = 3'd3,
    ST_IGNORED  = 3'd4
  } status_t;

  typedef struct packed {
    status_t           status;
    logic              start_send;
    logic [LEN_W-1:0]  xmit_bytes;
    logic [PAGE_W-1:0] send_page;
    logic              went_idle;
    logic              sequence_warning;
  } result_t;

endpackage

@@ design/dtbs_core.sv @@
// ----------------------------------------------------------------------------
// dtbs_core
// slot state and combinational event handling for the two transmit slots
// ----------------------------------------------------------------------------
module dtbs_core
  import dtbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  logic [1:0]        operation,
  input  logic [PLEN_W-1:0] packet_length,
  input  logic              error_aborted,
  input  logic              transmitter_busy,
  input  logic [PAGE_W-1:0] tx_base_page,
  output result_t           result
);

  mode_t              one_mode_r, one_mode_nxt;
  mode_t              two_mode_r, two_mode_nxt;
  logic [LEN_W-1:0]   one_len_r, one_len_nxt;
  logic [LEN_W-1:0]   two_len_r, two_len_nxt;
  code_t              code_r, code_nxt;
  logic               sending_r, sending_nxt;
  logic [QCNT_W-1:0]  qcnt_r, qcnt_nxt;

  logic [LEN_W-1:0]   pad_len;
  logic [LEN_W-1:0]   even_len;
  logic [PAGE_W-1:0]  page_one;
  logic [PAGE_W-1:0]  page_two;
  logic               use_two;

  assign pad_len  = ({1'b0, packet_length} < MIN_LEN) ? MIN_LEN : {1'b0, packet_length};
  assign even_len = pad_len + LEN_W'(pad_len[0]);
  assign page_one = tx_base_page;
  assign page_two = tx_base_page + SLOT_TWO_OFFSET;

  always_comb begin
    one_mode_nxt = one_mode_r;
    two_mode_nxt = two_mode_r;
    one_len_nxt  = one_len_r;
    two_len_nxt  = two_len_r;
    code_nxt     = code_r;
    sending_nxt  = sending_r;
    qcnt_nxt     = qcnt_r;
    use_two      = 1'b0;
    result       = '0;
    result.status = ST_IGNORED;

    if (item_valid) begin
      case (op_t'(operation))
        OP_SUBMIT: begin
          if (one_mode_r == MODE_FREE || two_mode_r == MODE_FREE) begin
            use_two = (one_mode_r != MODE_FREE);
            if (use_two) begin
              two_mode_nxt = MODE_LOADED;
              two_len_nxt  = even_len;
            end else begin
              one_mode_nxt = MODE_LOADED;
              one_len_nxt  = even_len;
            end
            if (!sending_r) begin
              sending_nxt   = 1'b1;
              result.status = ST_STARTED;
              if (!transmitter_busy) begin
                result.start_send = 1'b1;
                result.xmit_bytes = even_len;
                result.send_page  = use_two ? page_two : page_one;
              end
              if (use_two) begin
                two_mode_nxt = MODE_SENDING;
                code_nxt     = CODE_SUBMIT_TWO;
              end else begin
                one_mode_nxt = MODE_SENDING;
                code_nxt     = CODE_SUBMIT_ONE;
              end
            end else begin
              qcnt_nxt      = qcnt_r + 1'b1;
              result.status = ST_QUEUED;
            end
          end else begin
            result.status = ST_REJECTED;
          end
        end
        OP_DONE, OP_ERROR: begin
          if (op_t'(operation) == OP_DONE || error_aborted) begin
            result.status = ST_HANDLED;
            qcnt_nxt      = qcnt_r - 1'b1;
            if (one_mode_r == MODE_SENDING) begin
              result.sequence_warning = (code_r != CODE_RESTART_ONE) &&
                                        (code_r != CODE_SUBMIT_ONE);
              one_mode_nxt = MODE_FREE;
              one_len_nxt  = '0;
              if (two_mode_r == MODE_LOADED) begin
                sending_nxt = 1'b1;
                if (!transmitter_busy) begin
                  result.start_send = 1'b1;
                  result.xmit_bytes = two_len_r;
                  result.send_page  = page_two;
                end
                two_mode_nxt = MODE_SENDING;
                code_nxt     = CODE_RESTART_TWO;
              end else begin
                code_nxt         = CODE_IDLE_AFTER_ONE;
                sending_nxt      = 1'b0;
                result.went_idle = 1'b1;
              end
            end else if (two_mode_r == MODE_SENDING) begin
              result.sequence_warning = (code_r != CODE_RESTART_TWO) &&
                                        (code_r != CODE_SUBMIT_TWO);
              two_mode_nxt = MODE_FREE;
              two_len_nxt  = '0;
              if (one_mode_r == MODE_LOADED) begin
                sending_nxt = 1'b1;
                if (!transmitter_busy) begin
                  result.start_send = 1'b1;
                  result.xmit_bytes = one_len_r;
                  result.send_page  = page_one;
                end
                one_mode_nxt = MODE_SENDING;
                code_nxt     = CODE_RESTART_ONE;
              end else begin
                code_nxt         = CODE_IDLE_AFTER_TWO;
                sending_nxt      = 1'b0;
                result.went_idle = 1'b1;
              end
            end
          end
        end
        default: begin
          result.status = ST_IGNORED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_mode_r <= MODE_FREE;
      two_mode_r <= MODE_FREE;
      one_len_r  <= '0;
      two_len_r  <= '0;
      code_r     <= CODE_NONE;
      sending_r  <= 1'b0;
      qcnt_r     <= '0;
    end else begin
      one_mode_r <= one_mode_nxt;
      two_mode_r <= two_mode_nxt;
      one_len_r  <= one_len_nxt;
      two_len_r  <= two_len_nxt;
      code_r     <= code_nxt;
      sending_r  <= sending_nxt;
      qcnt_r     <= qcnt_nxt;
    end
  end

  a_one_sender : assert property (@(posedge clk) disable iff (!rst_n)
    !(one_mode_r == MODE_SENDING && two_mode_r == MODE_SENDING))
    else $error("both slots sending");

  a_sending_flag : assert property (@(posedge clk) disable iff (!rst_n)
    sending_r == (one_mode_r == MODE_SENDING || two_mode_r == MODE_SENDING))
    else $error("sending flag out of step with slot modes");

  a_free_len : assert property (@(posedge clk) disable iff (!rst_n)
    (one_mode_r != MODE_FREE || one_len_r == '0) &&
    (two_mode_r != MODE_FREE || two_len_r == '0))
    else $error("free slot holds a length");

  a_idle_stops : assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && result.went_idle) |=> !sending_r)
    else $error("still sending after going idle");

endmodule

@@ design/dual_tx_buffer_scheduler.sv @@
// ----------------------------------------------------------------------------
// dual_tx_buffer_scheduler
// ping-pong scheduler for two transmit buffer slots
// ----------------------------------------------------------------------------
// One transaction is taken in every clock cycle (busy stays low) and each one
// yields exactly one result, shown with out_valid for a single cycle; it passes
// the input register, then the slot logic into the result register. The
// receiver cannot stall the result path, so it must take every out_valid cycle.
// The user must write tx_base_page with cfg_we only while no transaction is in
// flight (not enforced); slot two starts half the transmit pages above it.
module dual_tx_buffer_scheduler
  import dtbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_operation,
  input  logic [PLEN_W-1:0] in_packet_length,
  input  logic              in_error_aborted,
  input  logic              in_transmitter_busy,
  output logic              out_valid,
  output logic [2:0]        out_status,
  output logic              out_start_send,
  output logic [LEN_W-1:0]  out_xmit_bytes,
  output logic [PAGE_W-1:0] out_send_page,
  output logic              out_went_idle,
  output logic              out_sequence_warning,
  input  logic              cfg_we,
  input  logic [PAGE_W-1:0] cfg_wdata
);

  logic              in_valid_r;
  logic [1:0]        op_r;
  logic [PLEN_W-1:0] plen_r;
  logic              aborted_r;
  logic              tx_busy_r;
  logic [PAGE_W-1:0] base_page_r;
  logic              out_valid_r;
  result_t           result_nxt;
  result_t           result_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      base_page_r <= BASE_PAGE_RST;
    end else begin
      in_valid_r  <= start && !busy;
      out_valid_r <= in_valid_r;
      if (cfg_we) begin
        base_page_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= in_operation;
    plen_r    <= in_packet_length;
    aborted_r <= in_error_aborted;
    tx_busy_r <= in_transmitter_busy;
    result_r  <= result_nxt;
  end

  dtbs_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (in_valid_r),
    .operation        (op_r),
    .packet_length    (plen_r),
    .error_aborted    (aborted_r),
    .transmitter_busy (tx_busy_r),
    .tx_base_page     (base_page_r),
    .result           (result_nxt)
  );

  assign out_valid            = out_valid_r;
  assign out_status           = result_r.status;
  assign out_start_send       = result_r.start_send;
  assign out_xmit_bytes       = result_r.xmit_bytes;
  assign out_send_page        = result_r.send_page;
  assign out_went_idle        = result_r.went_idle;
  assign out_sequence_warning = result_r.sequence_warning;

  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    start |=> ##1 out_valid)
    else $error("transaction without result");

  a_start_status : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_start_send) |->
      (result_r.status == ST_STARTED || result_r.status == ST_HANDLED))
    else $error("start issued with wrong status");

  a_idle_no_start : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_went_idle) |->
      (!out_start_send && result_r.status == ST_HANDLED))
    else $error("idle report with start");

endmodule
